// ===== hdl/ths_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ths_pkg
// Constants, types and helpers for the terrain height sampler.
// ============================================================================
package ths_pkg;

	localparam int GRID_MAX_SIDE = 256;
	localparam int FRACTION_BITS = 8;

	localparam int ADDR_W  = 16;
	localparam int POS_W   = 16;
	localparam int SAMPLE_W = 8;
	localparam int CFG_W   = 9;
	localparam int OUT_W   = 16;
	localparam int OUT_FRAC = 8;

	localparam int IDX_W   = POS_W - FRACTION_BITS;
	localparam int SIDE_W  = $clog2(GRID_MAX_SIDE + 1);
	localparam int ROW_W   = IDX_W + SIDE_W;
	localparam int WGT_W   = FRACTION_BITS + 1;
	localparam int PROD_W  = SAMPLE_W + WGT_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int DEPTH   = 1 << ADDR_W;

	localparam int SH_DN   = (FRACTION_BITS > OUT_FRAC) ? FRACTION_BITS - OUT_FRAC : 0;
	localparam int SH_UP   = (FRACTION_BITS < OUT_FRAC) ? OUT_FRAC - FRACTION_BITS : 0;
	localparam logic [ACC_W-1:0] ROUND_HALF = (SH_DN > 0) ? ACC_W'(1) << (SH_DN - 1) : '0;

	localparam logic [WGT_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [OUT_W-1:0] HEIGHT_MAX = OUT_W'(((1 << SAMPLE_W) - 1) << OUT_FRAC);

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (int'(v) < 2) begin
			r = SIDE_W'(2);
		end else if (int'(v) > GRID_MAX_SIDE) begin
			r = SIDE_W'(GRID_MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/terrain_height_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// terrain_height_sampler
// Height grid with triangle plane interpolation of fixed-point queries.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    mode, sample_index, sample_value,
//                                             query_x, query_z
// output    out        out_valid / out_stall  height, out_of_range
// config    in         cfg_we                 cfg_index, cfg_data
//
// One word is taken per cycle while the output is not stalled; a query's result
// word passes the s1 to s5 registers and is offered from s5.
// The rate is set by the sample store, kept in two copies that are written
// together so that three corners are read in the same cycle.
// Reset clears the valid bits and sets both grid sides to their maximum.
// The sample store is not cleared.
// A stall on the output while a result word is offered holds every stage and stalls the input in the same cycle.

module terrain_height_sampler (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             mode,
	input  wire logic [ths_pkg::ADDR_W-1:0]       sample_index,
	input  wire logic [ths_pkg::SAMPLE_W-1:0]     sample_value,
	input  wire logic [ths_pkg::POS_W-1:0]        query_x,
	input  wire logic [ths_pkg::POS_W-1:0]        query_z,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [ths_pkg::OUT_W-1:0]             height,
	output logic                                  out_of_range,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [ths_pkg::CFG_W-1:0]        cfg_data
);

	localparam int FB = ths_pkg::FRACTION_BITS;
	localparam int AW = ths_pkg::ADDR_W;
	localparam int WW = ths_pkg::WGT_W;

	logic [ths_pkg::SIDE_W-1:0] width_q, depth_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic                          mode_s1;
	logic [AW-1:0]                 sidx_s1;
	logic [ths_pkg::SAMPLE_W-1:0]  sval_s1;
	logic [ths_pkg::POS_W-1:0]     qx_s1, qz_s1;

	logic [ths_pkg::IDX_W-1:0]     ix, iz;
	logic [FB-1:0]                 fx, fz;
	logic [ths_pkg::ROW_W-1:0]     rowbase;
	logic [AW-1:0]                 base, wid16;
	logic [WW-1:0]                 fsum, wc, w10, w01;
	logic                          lower, oor;

	logic                          q_s2, oor_s2;
	logic [AW-1:0]                 a10_s2, a01_s2, ac_s2;
	logic [ths_pkg::SAMPLE_W-1:0]  data_s2;
	logic [WW-1:0]                 wc_s2, w10_s2, w01_s2;

	logic                          oor_s3;
	logic [ths_pkg::SAMPLE_W-1:0]  h10_s3, h01_s3, hc_s3;
	logic [WW-1:0]                 wc_s3, w10_s3, w01_s3;

	logic                          oor_s4;
	logic [ths_pkg::PROD_W-1:0]    pc_s4, p10_s4, p01_s4;

	logic [ths_pkg::ACC_W-1:0]     acc, acc_r;
	logic [ths_pkg::OUT_W-1:0]     hq;

	logic                          oor_s5;
	logic [ths_pkg::OUT_W-1:0]     height_s5;

	logic [ths_pkg::SAMPLE_W-1:0]  mem_a [ths_pkg::DEPTH];
	logic [ths_pkg::SAMPLE_W-1:0]  mem_b [ths_pkg::DEPTH];

	assign adv      = !(v_s5 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ths_pkg::SIDE_W'(ths_pkg::GRID_MAX_SIDE);
			depth_q <= ths_pkg::SIDE_W'(ths_pkg::GRID_MAX_SIDE);
		end else if (cfg_we) begin
			unique case (ths_pkg::cfg_reg_t'(cfg_index))
				ths_pkg::REG_GRID_WIDTH:  width_q <= ths_pkg::clamp_side(cfg_data);
				ths_pkg::REG_GRID_HEIGHT: depth_q <= ths_pkg::clamp_side(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && q_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		ix      = qx_s1[ths_pkg::POS_W-1:FB];
		iz      = qz_s1[ths_pkg::POS_W-1:FB];
		fx      = qx_s1[FB-1:0];
		fz      = qz_s1[FB-1:0];
		rowbase = ths_pkg::ROW_W'(iz) * ths_pkg::ROW_W'(width_q);
		base    = AW'(ix) + AW'(rowbase);
		wid16   = AW'(width_q);
		oor     = (17'(ix) + 17'd1 >= 17'(width_q)) || (17'(iz) + 17'd1 >= 17'(depth_q));
		fsum    = WW'(fx) + WW'(fz);
		lower   = fsum < ths_pkg::ONE;
		if (lower) begin
			wc  = ths_pkg::ONE - fsum;
			w10 = WW'(fx);
			w01 = WW'(fz);
		end else begin
			wc  = fsum - ths_pkg::ONE;
			w10 = ths_pkg::ONE - WW'(fz);
			w01 = ths_pkg::ONE - WW'(fx);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			sidx_s1 <= sample_index;
			sval_s1 <= sample_value;
			qx_s1   <= query_x;
			qz_s1   <= query_z;

			q_s2    <= mode_s1;
			oor_s2  <= oor;
			data_s2 <= sval_s1;
			a01_s2  <= base + wid16;
			if (mode_s1) begin
				a10_s2 <= base + AW'(1);
				ac_s2  <= lower ? base : base + wid16 + AW'(1);
			end else begin
				a10_s2 <= sidx_s1;
				ac_s2  <= sidx_s1;
			end
			wc_s2   <= wc;
			w10_s2  <= w10;
			w01_s2  <= w01;

			oor_s3  <= oor_s2;
			wc_s3   <= wc_s2;
			w10_s3  <= w10_s2;
			w01_s3  <= w01_s2;

			oor_s4  <= oor_s3;
			pc_s4   <= ths_pkg::PROD_W'(hc_s3) * ths_pkg::PROD_W'(wc_s3);
			p10_s4  <= ths_pkg::PROD_W'(h10_s3) * ths_pkg::PROD_W'(w10_s3);
			p01_s4  <= ths_pkg::PROD_W'(h01_s3) * ths_pkg::PROD_W'(w01_s3);

			oor_s5    <= oor_s4;
			height_s5 <= oor_s4 ? '0 : hq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && !q_s2) begin
			mem_a[a10_s2] <= data_s2;
		end
		if (adv) begin
			h10_s3 <= mem_a[a10_s2];
			h01_s3 <= mem_a[a01_s2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && !q_s2) begin
			mem_b[ac_s2] <= data_s2;
		end
		if (adv) begin
			hc_s3 <= mem_b[ac_s2];
		end
	end

	always_comb begin
		acc   = ths_pkg::ACC_W'(pc_s4) + ths_pkg::ACC_W'(p10_s4) + ths_pkg::ACC_W'(p01_s4);
		acc_r = (acc + ths_pkg::ROUND_HALF) >> ths_pkg::SH_DN;
		hq    = ths_pkg::OUT_W'(acc_r) << ths_pkg::SH_UP;
	end

	assign out_valid    = v_s5;
	assign height       = height_s5;
	assign out_of_range = oor_s5;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (height == '0))
		else $error("out-of-range word carries a nonzero height");

	a_height_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (height <= ths_pkg::HEIGHT_MAX))
		else $error("height exceeds the largest sample value");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && !q_s2) |=> !v_s3)
		else $error("load word passed the store stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(v_s2) && $stable(v_s3) && $stable(v_s4)))
		else $error("pipeline moved during an output stall");

endmodule
`default_nettype wire

// ===== sim/terrain_height_sampler_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// terrain_height_sampler_test
// Self-checking bench for the height grid sampler. Loads and queries go in
// through the input channel with random gaps, while the output side stalls in
// random bursts. Each query word is predicted from a mirror of the sample
// store and the grid registers and then checked field by field. The grid size
// changes between phases only while nothing is in flight.
// ============================================================================

module terrain_height_sampler_test;
	import ths_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int LATENCY       = 5;
	localparam int SETTLE_CYCLES = LATENCY + 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_WORDS  = 1400;
	localparam int TOTAL_WORDS   = 1650;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} word_mode_t;

	typedef struct {
		word_mode_t            op;
		logic [ADDR_W-1:0]     index;
		logic [SAMPLE_W-1:0]   value;
		logic [POS_W-1:0]      qx;
		logic [POS_W-1:0]      qz;
	} input_word_t;

	typedef struct {
		logic [OUT_W-1:0] height;
		logic             outside;
	} height_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                mode         = MODE_LOAD;
	logic [ADDR_W-1:0]   sample_index = '0;
	logic [SAMPLE_W-1:0] sample_value = '0;
	logic [POS_W-1:0]    query_x      = '0;
	logic [POS_W-1:0]    query_z      = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [OUT_W-1:0]    height;
	logic                out_of_range;
	logic                cfg_we       = 1'b0;
	cfg_reg_t            cfg_index    = REG_GRID_WIDTH;
	logic [CFG_W-1:0]    cfg_data     = '0;

	bit [SAMPLE_W-1:0]   sample_mirror [DEPTH];
	bit                  sample_loaded [DEPTH];
	logic [CFG_W-1:0]    width_reg    = CFG_W'(256);
	logic [CFG_W-1:0]    height_reg   = CFG_W'(256);
	height_result_t      expected_heights [$];

	int words_taken  = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int tx_idle_pct  = 20;
	int rx_idle_pct  = 20;
	int stall_left   = 0;

	terrain_height_sampler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.query_x      (query_x),
		.query_z      (query_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.height       (height),
		.out_of_range (out_of_range),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int used_side(input logic [CFG_W-1:0] raw);
		int side;
		side = int'(raw);
		if (side < 2) begin
			side = 2;
		end else if (side > GRID_MAX_SIDE) begin
			side = GRID_MAX_SIDE;
		end
		return side;
	endfunction

	function automatic int corner_addr(input int x, input int z, input int w);
		return (x + z * w) & (DEPTH - 1);
	endfunction

	function automatic height_result_t interpolate_height(input logic [POS_W-1:0] qx,
			input logic [POS_W-1:0] qz);
		height_result_t r;
		longint one, fx, fz, acc, h00, h10, h01, h11;
		int ix, iz, w, h, sh;
		one = longint'(1) << FRACTION_BITS;
		ix = int'(qx >> FRACTION_BITS);
		iz = int'(qz >> FRACTION_BITS);
		fx = longint'(qx) & (one - 1);
		fz = longint'(qz) & (one - 1);
		w = used_side(width_reg);
		h = used_side(height_reg);
		if (ix + 1 >= w || iz + 1 >= h) begin
			r.height = '0;
			r.outside = 1'b1;
		end else begin
			h00 = sample_mirror[corner_addr(ix, iz, w)];
			h10 = sample_mirror[corner_addr(ix + 1, iz, w)];
			h01 = sample_mirror[corner_addr(ix, iz + 1, w)];
			h11 = sample_mirror[corner_addr(ix + 1, iz + 1, w)];
			if (fx + fz < one) begin
				acc = h00 * (one - fx - fz) + h10 * fx + h01 * fz;
			end else begin
				acc = h11 * (fx + fz - one) + h01 * (one - fx) + h10 * (one - fz);
			end
			sh = FRACTION_BITS - OUT_FRAC;
			if (sh > 0) begin
				acc = (acc + (longint'(1) << (sh - 1))) >> sh;
			end else begin
				acc = acc << (-sh);
			end
			r.height = OUT_W'(acc);
			r.outside = 1'b0;
		end
		return r;
	endfunction

	// The mirror follows the block in the order in which words are taken.
	task automatic send_word(input input_word_t wd);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= wd.op;
		sample_index <= wd.index;
		sample_value <= wd.value;
		query_x      <= wd.qx;
		query_z      <= wd.qz;
		do @(posedge clk); while (in_stall);
		if (wd.op == MODE_LOAD) begin
			sample_mirror[wd.index] = wd.value;
			sample_loaded[wd.index] = 1'b1;
		end else begin
			expected_heights.push_back(interpolate_height(wd.qx, wd.qz));
		end
		words_taken++;
	endtask

	task automatic load_sample(input logic [ADDR_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		input_word_t wd;
		wd.op = MODE_LOAD;
		wd.index = idx;
		wd.value = val;
		wd.qx = POS_W'($urandom);
		wd.qz = POS_W'($urandom);
		send_word(wd);
	endtask

	task automatic query_at(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz);
		input_word_t wd;
		wd.op = MODE_QUERY;
		wd.index = ADDR_W'($urandom);
		wd.value = SAMPLE_W'($urandom);
		wd.qx = qx;
		wd.qz = qz;
		send_word(wd);
	endtask

	// Corners that were never loaded are loaded first, so no query reads an
	// undefined sample. Some loaded corners are rewritten right before the query.
	task automatic query_with_corners(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz,
			input int rewrite_pct);
		int w, h, ix, iz;
		int addr [4];
		w = used_side(width_reg);
		h = used_side(height_reg);
		ix = int'(qx >> FRACTION_BITS);
		iz = int'(qz >> FRACTION_BITS);
		if (ix + 1 < w && iz + 1 < h) begin
			addr[0] = corner_addr(ix, iz, w);
			addr[1] = corner_addr(ix + 1, iz, w);
			addr[2] = corner_addr(ix, iz + 1, w);
			addr[3] = corner_addr(ix + 1, iz + 1, w);
			foreach (addr[k]) begin
				if (!sample_loaded[addr[k]] || $urandom_range(99) < rewrite_pct) begin
					load_sample(ADDR_W'(addr[k]), SAMPLE_W'($urandom));
				end
			end
		end
		query_at(qx, qz);
	endtask

	task automatic random_query(input int rewrite_pct);
		int w, h;
		logic [IDX_W-1:0] ix, iz;
		logic [FRACTION_BITS-1:0] fx, fz;
		w = used_side(width_reg);
		h = used_side(height_reg);
		ix = IDX_W'($urandom_range(0, w - 2));
		iz = IDX_W'($urandom_range(0, h - 2));
		fx = FRACTION_BITS'($urandom);
		fz = FRACTION_BITS'($urandom);
		case ($urandom_range(9))
			0: begin
				ix = IDX_W'($urandom);
				iz = IDX_W'($urandom);
			end
			1: ix = IDX_W'($urandom_range(w - 1, (1 << IDX_W) - 1));
			2: iz = IDX_W'($urandom_range(h - 1, (1 << IDX_W) - 1));
			3: fz = ~fx;
			4: fz = -fx;
			default: ;
		endcase
		query_with_corners({ix, fx}, {iz, fz}, rewrite_pct);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_heights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_GRID_WIDTH:  width_reg = value;
			REG_GRID_HEIGHT: height_reg = value;
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
		drain_results();
		write_reg(REG_GRID_WIDTH, w_raw);
		write_reg(REG_GRID_HEIGHT, h_raw);
		cfg_we <= 1'b0;
	endtask

	task automatic probe_grid(input int count);
		repeat (count) random_query(20);
	endtask

	// Corner cell and far cell of the full grid after reset, both triangles and
	// the diagonal between them, then cells that leave the grid.
	task automatic test_directed_cells();
		load_sample(16'h0000, 8'h00);
		load_sample(16'h0001, 8'hFF);
		load_sample(16'h0100, 8'hFF);
		load_sample(16'h0101, 8'h00);
		query_at(16'h0000, 16'h0000);
		query_at(16'h00FF, 16'h0000);
		query_at(16'h0000, 16'h00FF);
		query_at(16'h0080, 16'h007F);
		query_at(16'h0080, 16'h0080);
		query_at(16'h00FF, 16'h00FF);
		load_sample(16'hFEFE, 8'hFF);
		load_sample(16'hFEFF, 8'hFF);
		load_sample(16'hFFFE, 8'hFF);
		load_sample(16'hFFFF, 8'hFF);
		query_at(16'hFE00, 16'hFE00);
		load_sample(16'hFFFF, 8'h00);
		query_at(16'hFEFF, 16'hFEFF);
		query_at(16'hFF00, 16'h0000);
		query_at(16'h0000, 16'hFF00);
		query_at(16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_grid_extremes();
		set_grid(CFG_W'(0), CFG_W'(1));
		query_with_corners(16'h0000, 16'h00FF, 0);
		query_at(16'h0100, 16'h0000);
		probe_grid(6);
		set_grid(CFG_W'(511), CFG_W'(257));
		probe_grid(6);
		set_grid(CFG_W'(2), CFG_W'(256));
		probe_grid(6);
		set_grid(CFG_W'(256), CFG_W'(2));
		probe_grid(6);
		set_grid(CFG_W'(3), CFG_W'(5));
		probe_grid(6);
	endtask

	task automatic test_random_phases();
		int w_raw, h_raw;
		while (words_taken < RANDOM_WORDS) begin
			case ($urandom_range(7))
				0: begin
					w_raw = $urandom_range(0, 511);
					h_raw = $urandom_range(0, 511);
				end
				1: begin
					w_raw = 256;
					h_raw = 256;
				end
				2: begin
					w_raw = 2;
					h_raw = 2;
				end
				3: begin
					w_raw = $urandom_range(2, 256);
					h_raw = $urandom_range(2, 256);
				end
				default: begin
					w_raw = $urandom_range(2, 12);
					h_raw = $urandom_range(2, 12);
				end
			endcase
			set_grid(CFG_W'(w_raw), CFG_W'(h_raw));
			case ($urandom_range(2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 10;
				default: tx_idle_pct = 35;
			endcase
			case ($urandom_range(2))
				0: rx_idle_pct = 0;
				1: rx_idle_pct = 10;
				default: rx_idle_pct = 35;
			endcase
			for (int n = 0; n < 40; n++) begin
				if (n == 20 && $urandom_range(1) == 1) begin
					drain_results();
				end
				if ($urandom_range(9) == 0) begin
					load_sample(ADDR_W'($urandom), SAMPLE_W'($urandom));
				end else begin
					random_query(25);
				end
			end
		end
	endtask

	task automatic test_full_rate_finish();
		set_grid(CFG_W'($urandom_range(2, 16)), CFG_W'($urandom_range(2, 16)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (words_taken < TOTAL_WORDS) random_query(30);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		height_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_heights.size() == 0) begin
				mismatches++;
				$display("%0t: result word with none expected, height %0d out_of_range %0b",
					$time, height, out_of_range);
			end else begin
				want = expected_heights.pop_front();
				if (height !== want.height) begin
					mismatches++;
					$display("%0t: height expected %0d actual %0d", $time, want.height, height);
				end
				if (out_of_range !== want.outside) begin
					mismatches++;
					$display("%0t: out_of_range expected %0b actual %0b",
						$time, want.outside, out_of_range);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cells();
		test_grid_extremes();
		test_random_phases();
		test_full_rate_finish();
		in_valid <= 1'b0;
		while (expected_heights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ths_pkg.sv
hdl/terrain_height_sampler.sv
sim/terrain_height_sampler_test.sv
